// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every rising edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// when pre holds, post must hold in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== sv/era_pkg.sv =====
package era_pkg;

    // Fixed field widths
    localparam int DATA_W     = 32;
    localparam int IDX_FIELD_W = 8;
    localparam int OPCODE_W   = 4;

    // Parameter defaults
    localparam int NUM_REGISTERS_DEF = 256;
    localparam int FRACTION_BITS_DEF = 16;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_MUL = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_DIV = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_MOD = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_ADD = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_SUB = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_GT  = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_LT  = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_GE  = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_LE  = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_EQ  = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_NE  = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_AND = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_OR  = 4'd12;

    // Mode codes
    localparam logic MODE_PRESET = 1'b0;
    localparam logic MODE_EXEC   = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic [OPCODE_W-1:0]         opcode;
        logic [IDX_FIELD_W-1:0]      src_a;
        logic [IDX_FIELD_W-1:0]      src_b;
        logic [IDX_FIELD_W-1:0]      dest;
        logic signed [DATA_W-1:0]    preset_value;
        logic                        last_op;
    } req_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]      written_index;
        logic signed [DATA_W-1:0]    written_value;
        logic                        div_zero;
        logic                        saturated;
        logic                        last;
    } res_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_LOAD_C,
        S_DIV,
        S_WRITE
    } state_t;

    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_C
    } rd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_req;
        rd_sel_t rd_sel;
        logic    load_a;
        logic    load_b;
        logic    load_c;
        logic    div_start;
        logic    load_res;
        logic    clear_step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_exec;
        logic op_mul;
        logic op_div;
        logic b_zero;
        logic div_busy;
        logic div_done;
        logic res_free;
        logic clear_done;
    } sts_t;

endpackage

// ===== sv/era_ram.sv =====
module era_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/era_div.sv =====
module era_div #(
    parameter int DIVIDEND_W = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [31:0]           divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [31:0]           remainder,
    output logic                  busy,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           dvs_reg, dvs_next;
    logic [32:0]           trial;
    logic [32:0]           diff;

    assign done = busy_reg && (cnt_reg == CNT_W'(DIVIDEND_W - 1));

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb
    begin
        trial     = {rem_reg, q_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                q_next   = {q_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;

endmodule

// ===== sv/era_datapath.sv =====
module era_datapath #(
    parameter int NUM_REGISTERS = era_pkg::NUM_REGISTERS_DEF,
    parameter int FRACTION_BITS = era_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  era_pkg::req_t req_data,
    input  era_pkg::cmd_t cmd,
    output era_pkg::sts_t sts,
    output logic          res_valid,
    input  logic          res_stall,
    output era_pkg::res_t res_data
);

    localparam int IDX_W = $clog2(NUM_REGISTERS);
    localparam int DW    = era_pkg::DATA_W;
    localparam int DIV_W = DW + FRACTION_BITS;

    localparam logic [DW-1:0]    ONE_VAL   = DW'(1) << FRACTION_BITS;
    localparam logic [DW-1:0]    INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [DW-1:0]    INT_MIN   = 32'h8000_0000;
    localparam logic [DIV_W-1:0] Q_POS_MAX = DIV_W'(32'h7FFF_FFFF);
    localparam logic [DIV_W-1:0] Q_NEG_MAX = DIV_W'(32'h8000_0000);
    localparam logic signed [63:0] S_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S_MIN = -64'sh0000_0000_8000_0000;

    // index field reduced modulo the register count by conditional subtracts
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [7:0] f);
        logic [15:0] v;
        v = {8'd0, f};
        for (int k = 3; k >= 0; k--)
        begin
            if ((NUM_REGISTERS << k) <= 255)
            begin
                if (v >= 16'(NUM_REGISTERS << k))
                begin
                    v = v - 16'(NUM_REGISTERS << k);
                end
            end
        end
        return v[IDX_W-1:0];
    endfunction

    // captured request
    logic                    mode_reg;
    logic [3:0]              op_reg;
    logic [IDX_W-1:0]        ia_reg, ib_reg, ic_reg;
    logic signed [DW-1:0]    preset_reg;
    logic                    last_reg;

    // operands and product
    logic signed [DW-1:0]    a_reg, b_reg, c_reg;
    logic signed [63:0]      prod_reg;

    // clearing pass
    logic [IDX_W-1:0]        clr_reg, clr_next;

    // result register
    logic                    res_valid_reg, res_valid_next;
    era_pkg::res_t           res_reg;

    // memory ports
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [DW-1:0]           ram_wdata, ram_rdata;

    // divider
    logic [DW-1:0]           a_mag, b_mag;
    logic [DIV_W-1:0]        dividend, quotient;
    logic [DW-1:0]           remainder;
    logic                    div_busy, div_done;

    // result logic
    logic signed [DW-1:0]    result;
    logic                    dz, sat, wr_en;
    logic signed [63:0]      mul_s;
    logic signed [DW:0]      sum_ext;
    logic [DW-1:0]           rem_trunc;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg   <= req_data.mode;
            op_reg     <= req_data.opcode;
            ia_reg     <= wrap_idx(req_data.src_a);
            ib_reg     <= wrap_idx(req_data.src_b);
            ic_reg     <= wrap_idx(req_data.dest);
            preset_reg <= req_data.preset_value;
            last_reg   <= req_data.last_op;
        end
        if (cmd.load_a)
        begin
            a_reg <= ram_rdata;
        end
        if (cmd.load_b)
        begin
            b_reg <= ram_rdata;
        end
        if (cmd.load_c)
        begin
            c_reg <= ram_rdata;
        end
        prod_reg <= a_reg * b_reg;
        if (cmd.load_res)
        begin
            res_reg.written_index <= 8'(ic_reg);
            res_reg.written_value <= result;
            res_reg.div_zero      <= dz;
            res_reg.saturated     <= sat;
            res_reg.last          <= last_reg;
        end
    end

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            era_pkg::RD_A: ram_raddr = ia_reg;
            era_pkg::RD_B: ram_raddr = ib_reg;
            era_pkg::RD_C: ram_raddr = ic_reg;
            default:       ram_raddr = ia_reg;
        endcase
    end

    // write port: clearing pass or result write-back
    assign ram_we    = cmd.clear_step || (cmd.load_res && wr_en);
    assign ram_waddr = cmd.clear_step ? clr_reg : ic_reg;
    assign ram_wdata = cmd.clear_step ? '0 : result;

    era_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_REGISTERS)
    ) u_regfile (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider operands: magnitudes, dividend scaled for divide only
    assign a_mag    = a_reg[DW-1] ? (~a_reg + DW'(1)) : a_reg;
    assign b_mag    = b_reg[DW-1] ? (~b_reg + DW'(1)) : b_reg;
    assign dividend = (op_reg == era_pkg::OP_DIV) ? {a_mag, {FRACTION_BITS{1'b0}}}
                                                  : DIV_W'(a_mag);

    era_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (b_mag),
        .quotient  (quotient),
        .remainder (remainder),
        .busy      (div_busy),
        .done      (div_done)
    );

    // result select and saturation
    always_comb
    begin
        result    = '0;
        dz        = 1'b0;
        sat       = 1'b0;
        wr_en     = 1'b1;
        mul_s     = prod_reg >>> FRACTION_BITS;
        sum_ext   = '0;
        rem_trunc = {remainder[DW-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}};
        if (mode_reg == era_pkg::MODE_PRESET)
        begin
            result = preset_reg;
        end
        else
        begin
            case (op_reg)
                era_pkg::OP_MUL:
                begin
                    if (mul_s > S_MAX)
                    begin
                        result = INT_MAX;
                        sat    = 1'b1;
                    end
                    else if (mul_s < S_MIN)
                    begin
                        result = INT_MIN;
                        sat    = 1'b1;
                    end
                    else
                    begin
                        result = mul_s[DW-1:0];
                    end
                end
                era_pkg::OP_DIV:
                begin
                    if (b_reg == '0)
                    begin
                        dz = 1'b1;
                    end
                    else if (a_reg[DW-1] ^ b_reg[DW-1])
                    begin
                        if (quotient > Q_NEG_MAX)
                        begin
                            result = INT_MIN;
                            sat    = 1'b1;
                        end
                        else
                        begin
                            result = ~quotient[DW-1:0] + DW'(1);
                        end
                    end
                    else if (quotient > Q_POS_MAX)
                    begin
                        result = INT_MAX;
                        sat    = 1'b1;
                    end
                    else
                    begin
                        result = quotient[DW-1:0];
                    end
                end
                era_pkg::OP_MOD:
                begin
                    if (b_reg == '0)
                    begin
                        dz = 1'b1;
                    end
                    else
                    begin
                        result = a_reg[DW-1] ? (~rem_trunc + DW'(1)) : rem_trunc;
                    end
                end
                era_pkg::OP_ADD, era_pkg::OP_SUB:
                begin
                    if (op_reg == era_pkg::OP_ADD)
                    begin
                        sum_ext = {a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg};
                    end
                    else
                    begin
                        sum_ext = {a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg};
                    end
                    if (sum_ext[DW] != sum_ext[DW-1])
                    begin
                        sat    = 1'b1;
                        result = sum_ext[DW] ? INT_MIN : INT_MAX;
                    end
                    else
                    begin
                        result = sum_ext[DW-1:0];
                    end
                end
                era_pkg::OP_GT:  result = (a_reg >  b_reg) ? ONE_VAL : '0;
                era_pkg::OP_LT:  result = (a_reg <  b_reg) ? ONE_VAL : '0;
                era_pkg::OP_GE:  result = (a_reg >= b_reg) ? ONE_VAL : '0;
                era_pkg::OP_LE:  result = (a_reg <= b_reg) ? ONE_VAL : '0;
                era_pkg::OP_EQ:  result = (a_reg == b_reg) ? ONE_VAL : '0;
                era_pkg::OP_NE:  result = (a_reg != b_reg) ? ONE_VAL : '0;
                era_pkg::OP_AND:
                    result = ((a_reg != '0) && (b_reg != '0)) ? ONE_VAL : '0;
                era_pkg::OP_OR:
                    result = ((a_reg != '0) || (b_reg != '0)) ? ONE_VAL : '0;
                default:
                begin
                    // undefined opcode: report current contents, no write
                    result = c_reg;
                    wr_en  = 1'b0;
                end
            endcase
        end
    end

    // clear counter and result valid
    always_comb
    begin
        clr_next = cmd.clear_step ? (clr_reg + IDX_W'(1)) : clr_reg;
        res_valid_next = res_valid_reg;
        if (cmd.load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // status to controller
    always_comb
    begin
        sts.req_exec   = (req_data.mode == era_pkg::MODE_EXEC);
        sts.op_mul     = (op_reg == era_pkg::OP_MUL);
        sts.op_div     = (op_reg == era_pkg::OP_DIV) || (op_reg == era_pkg::OP_MOD);
        sts.b_zero     = (b_reg == '0);
        sts.div_busy   = div_busy;
        sts.div_done   = div_done;
        sts.res_free   = !res_valid_reg || !res_stall;
        sts.clear_done = (clr_reg == IDX_W'(NUM_REGISTERS - 1));
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ===== sv/era_ctrl.sv =====
`include "assert_macros.svh"

module era_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  era_pkg::sts_t sts,
    output era_pkg::cmd_t cmd
);

    era_pkg::state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            era_pkg::S_CLEAR:
                if (sts.clear_done)
                begin
                    state_next = era_pkg::S_IDLE;
                end
            era_pkg::S_IDLE:
                if (req_valid)
                begin
                    state_next = sts.req_exec ? era_pkg::S_RD_A : era_pkg::S_WRITE;
                end
            era_pkg::S_RD_A:   state_next = era_pkg::S_RD_B;
            era_pkg::S_RD_B:   state_next = era_pkg::S_RD_C;
            era_pkg::S_RD_C:   state_next = era_pkg::S_LOAD_C;
            era_pkg::S_LOAD_C:
                if (sts.op_div && !sts.b_zero)
                begin
                    state_next = era_pkg::S_DIV;
                end
                else
                begin
                    state_next = era_pkg::S_WRITE;
                end
            era_pkg::S_DIV:
                if (sts.div_done)
                begin
                    state_next = era_pkg::S_WRITE;
                end
            era_pkg::S_WRITE:
                if (sts.res_free)
                begin
                    state_next = era_pkg::S_IDLE;
                end
            default: state_next = era_pkg::S_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = era_pkg::RD_A;
        req_stall      = 1'b1;
        unique case (state_reg)
            era_pkg::S_CLEAR:
                cmd.clear_step = 1'b1;
            era_pkg::S_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.load_req = req_valid;
            end
            era_pkg::S_RD_A:
                cmd.rd_sel = era_pkg::RD_A;
            era_pkg::S_RD_B:
            begin
                cmd.rd_sel = era_pkg::RD_B;
                cmd.load_a = 1'b1;
            end
            era_pkg::S_RD_C:
            begin
                cmd.rd_sel = era_pkg::RD_C;
                cmd.load_b = 1'b1;
            end
            era_pkg::S_LOAD_C:
            begin
                cmd.load_c    = 1'b1;
                cmd.div_start = sts.op_div && !sts.b_zero;
            end
            era_pkg::S_DIV:
                cmd.rd_sel = era_pkg::RD_A;
            era_pkg::S_WRITE:
                cmd.load_res = sts.res_free;
            default:
                req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= era_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, (state_reg == era_pkg::S_IDLE) && req_valid, state_reg != era_pkg::S_IDLE, "request accepted but controller stayed idle")
    `ASSERT_ALWAYS(a_div_busy_in_div, clk, rst_n, (state_reg != era_pkg::S_DIV) || sts.div_busy, "divide state entered with divider idle")
    `ASSERT_NEXT(a_clear_holds, clk, rst_n, (state_reg == era_pkg::S_CLEAR) && !sts.clear_done, state_reg == era_pkg::S_CLEAR, "clearing pass left early")

endmodule

// ===== sv/expression_register_alu.sv =====
// Channel   | Signals                          | Payload
// ----------+----------------------------------+----------------------------
// request   | req_valid, req_stall, req_data   | era_pkg::req_t (in)
// result    | res_valid, res_stall, res_data   | era_pkg::res_t (out)
//
// One request at a time. A preset goes straight to write-back; an execute
// reads its three registers in turn through the single register-file
// read port. Divide and remainder also run the radix-2 divider over a
// 32 + FRACTION_BITS bit dividend (48 at the default), unless the divisor
// is zero. After reset a clearing pass writes zero to every register in
// turn, with req_stall high.
// A held result stalls only the write-back of the next request.
module expression_register_alu #(
    parameter int NUM_REGISTERS = era_pkg::NUM_REGISTERS_DEF,
    parameter int FRACTION_BITS = era_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  era_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output era_pkg::res_t res_data
);

    era_pkg::cmd_t cmd;
    era_pkg::sts_t sts;

    era_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    era_datapath #(
        .NUM_REGISTERS (NUM_REGISTERS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ===== test/expression_register_alu_tb.sv =====
`timescale 1ns / 1ps

module expression_register_alu_tb;
    import era_pkg::*;

    localparam int REG_COUNT      = 256;
    localparam int FRAC_BITS      = 16;
    localparam int TARGET_ITEMS   = 2000;
    localparam int CALM_ITEMS     = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 80;

    // Opcodes the block leaves undefined
    localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 4'd13;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 4'd15;

    localparam logic signed [63:0] FIX_ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] MAX32   = 64'sh7FFFFFFF;
    localparam logic signed [63:0] MIN32   = -64'sh80000000;

    typedef struct {
        req_t req;
        int   gap;
        bit   drain;
    } queued_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    queued_req_t pending_requests[$];
    res_t        expected_writes[$];
    logic signed [DATA_W-1:0] reg_shadow [REG_COUNT];

    int mismatches = 0;
    int quiet_cycles = 0;
    int hold_cnt = 0;
    int stall_left = 0;
    int gap_pct = 0;
    int items_made = 0;
    res_t want;

    expression_register_alu DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Clip a wide value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] clip32(input logic signed [63:0] v,
                                                        output logic clipped);
        clipped = 1'b0;
        if (v > MAX32)
        begin
            clipped = 1'b1;
            return MAX32[31:0];
        end
        if (v < MIN32)
        begin
            clipped = 1'b1;
            return MIN32[31:0];
        end
        return v[31:0];
    endfunction

    // Expected register write for one request; updates the shadow register file
    function automatic res_t predict_write(input req_t rq);
        res_t r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] rem;
        logic signed [DATA_W-1:0] value;
        logic clipped;
        logic dz;
        logic wr;
        clipped = 1'b0;
        dz = 1'b0;
        wr = 1'b1;
        value = '0;
        a = reg_shadow[rq.src_a];
        b = reg_shadow[rq.src_b];
        if (rq.mode == MODE_PRESET)
            value = rq.preset_value;
        else
        begin
            case (rq.opcode)
                OP_MUL: value = clip32((a * b) >>> FRAC_BITS, clipped);
                OP_DIV:
                begin
                    if (b == 0)
                        dz = 1'b1;
                    else
                        value = clip32((a * FIX_ONE) / b, clipped);
                end
                OP_MOD:
                begin
                    if (b == 0)
                        dz = 1'b1;
                    else
                    begin
                        rem = a % b;
                        rem = rem - (rem % FIX_ONE);
                        value = rem[31:0];
                    end
                end
                OP_ADD: value = clip32(a + b, clipped);
                OP_SUB: value = clip32(a - b, clipped);
                OP_GT:  value = (a > b) ? FIX_ONE[31:0] : '0;
                OP_LT:  value = (a < b) ? FIX_ONE[31:0] : '0;
                OP_GE:  value = (a >= b) ? FIX_ONE[31:0] : '0;
                OP_LE:  value = (a <= b) ? FIX_ONE[31:0] : '0;
                OP_EQ:  value = (a == b) ? FIX_ONE[31:0] : '0;
                OP_NE:  value = (a != b) ? FIX_ONE[31:0] : '0;
                OP_AND: value = (a != 0 && b != 0) ? FIX_ONE[31:0] : '0;
                OP_OR:  value = (a != 0 || b != 0) ? FIX_ONE[31:0] : '0;
                default:
                begin
                    // undefined opcode: report current contents, no write
                    wr = 1'b0;
                    value = reg_shadow[rq.dest];
                end
            endcase
        end
        if (wr)
            reg_shadow[rq.dest] = value;
        r.written_index = rq.dest;
        r.written_value = value;
        r.div_zero      = dz;
        r.saturated     = clipped;
        r.last          = rq.last_op;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Random Q16.16 operand: zeros, units, small fractions, integers, extremes, raw random words
    function automatic logic signed [DATA_W-1:0] rand_fixed();
        int k;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ($urandom_range(0, 1) != 0) ? FIX_ONE[31:0] : -FIX_ONE[31:0];
            2, 3:
            begin
                k = $urandom_range(0, 20'hFFFFF);
                return k - 32'sh80000;
            end
            4:
            begin
                k = $urandom_range(0, 40);
                return (k - 20) * 65536;
            end
            5:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t make_preset(input logic [7:0] dst,
                                         input logic signed [31:0] v, input logic lst);
        req_t rq;
        rq.mode         = MODE_PRESET;
        rq.opcode       = $urandom_range(0, 15);
        rq.src_a        = $urandom_range(0, 255);
        rq.src_b        = $urandom_range(0, 255);
        rq.dest         = dst;
        rq.preset_value = v;
        rq.last_op      = lst;
        return rq;
    endfunction

    function automatic req_t make_exec(input logic [OPCODE_W-1:0] op, input logic [7:0] sa,
                                       input logic [7:0] sb, input logic [7:0] dst,
                                       input logic lst);
        req_t rq;
        rq.mode         = MODE_EXEC;
        rq.opcode       = op;
        rq.src_a        = sa;
        rq.src_b        = sb;
        rq.dest         = dst;
        rq.preset_value = $urandom();
        rq.last_op      = lst;
        return rq;
    endfunction

    task automatic queue_request(input req_t rq, input bit drain);
        queued_req_t q;
        q.req   = rq;
        q.drain = drain;
        q.gap   = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 16) : 0;
        pending_requests.push_back(q);
        items_made++;
    endtask

    // One evaluation pass: presets then dependent operations; some noise mixed in
    task automatic queue_pass(input bit drain_first);
        int pool;
        int n_pre;
        int n_exec;
        int i;
        logic [OPCODE_W-1:0] op;
        logic [63:0] raw;
        req_t rq;
        pool = ($urandom_range(0, 7) == 0) ? 255 : 15;
        n_pre = $urandom_range(2, 11);
        n_exec = $urandom_range(4, 20);
        for (i = 0; i < n_pre + n_exec; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                raw = {$urandom(), $urandom()};
                rq = raw[$bits(req_t)-1:0];
            end
            else if (i < n_pre)
                rq = make_preset($urandom_range(0, pool), rand_fixed(), 1'b0);
            else
            begin
                op = ($urandom_range(0, 99) < 4) ? $urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)
                                                 : $urandom_range(OP_MUL, OP_OR);
                rq = make_exec(op, $urandom_range(0, pool), $urandom_range(0, pool),
                               $urandom_range(0, pool), 1'b0);
            end
            if (i == n_pre + n_exec - 1)
                rq.last_op = 1'b1;
            queue_request(rq, drain_first && i == 0);
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int pass_no;
        pass_no = 0;
        for (int i = 0; i < REG_COUNT; i++)
            reg_shadow[i] = '0;

        // directed: extremes, every operation, zero divisor, undefined opcodes
        queue_request(make_preset(8'd0, 32'sh00010000, 1'b0), 1'b0);
        queue_request(make_preset(8'd1, 32'sh00000000, 1'b0), 1'b0);
        queue_request(make_preset(8'd2, 32'sh7FFFFFFF, 1'b0), 1'b0);
        queue_request(make_preset(8'd3, 32'sh80000000, 1'b0), 1'b0);
        queue_request(make_preset(8'd4, 32'shFFFE8000, 1'b0), 1'b0);
        queue_request(make_preset(8'd5, 32'sh00028000, 1'b0), 1'b0);
        queue_request(make_preset(8'd255, 32'shFFFFFFFF, 1'b1), 1'b0);
        queue_request(make_exec(OP_MUL, 8'd2, 8'd2, 8'd6, 1'b0), 1'b0);
        queue_request(make_exec(OP_MUL, 8'd255, 8'd5, 8'd7, 1'b0), 1'b0);
        queue_request(make_exec(OP_MUL, 8'd3, 8'd2, 8'd8, 1'b0), 1'b0);
        queue_request(make_exec(OP_DIV, 8'd5, 8'd4, 8'd9, 1'b0), 1'b0);
        queue_request(make_exec(OP_DIV, 8'd0, 8'd1, 8'd10, 1'b0), 1'b0);
        queue_request(make_exec(OP_DIV, 8'd2, 8'd255, 8'd11, 1'b0), 1'b0);
        queue_request(make_exec(OP_MOD, 8'd5, 8'd1, 8'd12, 1'b0), 1'b0);
        queue_request(make_exec(OP_MOD, 8'd3, 8'd5, 8'd13, 1'b0), 1'b0);
        queue_request(make_exec(OP_ADD, 8'd2, 8'd0, 8'd14, 1'b0), 1'b0);
        queue_request(make_exec(OP_SUB, 8'd3, 8'd0, 8'd15, 1'b0), 1'b0);
        queue_request(make_exec(OP_GT, 8'd5, 8'd4, 8'd16, 1'b0), 1'b0);
        queue_request(make_exec(OP_LT, 8'd5, 8'd4, 8'd17, 1'b0), 1'b0);
        queue_request(make_exec(OP_GE, 8'd4, 8'd4, 8'd18, 1'b0), 1'b0);
        queue_request(make_exec(OP_LE, 8'd3, 8'd2, 8'd19, 1'b0), 1'b0);
        queue_request(make_exec(OP_EQ, 8'd1, 8'd1, 8'd20, 1'b0), 1'b0);
        queue_request(make_exec(OP_NE, 8'd1, 8'd1, 8'd21, 1'b0), 1'b0);
        queue_request(make_exec(OP_AND, 8'd0, 8'd1, 8'd22, 1'b0), 1'b0);
        queue_request(make_exec(OP_OR, 8'd0, 8'd1, 8'd23, 1'b0), 1'b0);
        queue_request(make_exec(OP_UNDEF_LO, 8'd0, 8'd1, 8'd6, 1'b0), 1'b0);
        queue_request(make_exec(OP_UNDEF_HI, 8'd2, 8'd3, 8'd255, 1'b1), 1'b0);

        // random passes; idling comes and goes in phases
        while (items_made < TARGET_ITEMS)
        begin
            if (pass_no % 8 == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            queue_pass(pass_no % 16 == 0);
            pass_no++;
        end

        @(posedge rst_n);
        while (pending_requests.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        queued_req_t item;
        logic launch;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            hold_cnt = 0;
        end
        else
        begin
            launch = 1'b0;
            if (!(req_valid && req_stall))
            begin
                if (hold_cnt > 0)
                    hold_cnt--;
                else if (pending_requests.size() > 0)
                begin
                    if (pending_requests[0].gap > 0 && pending_requests.size() >= CALM_ITEMS)
                    begin
                        hold_cnt = pending_requests[0].gap - 1;
                        pending_requests[0].gap = 0;
                    end
                    else if (pending_requests[0].drain &&
                             (req_valid || expected_writes.size() != 0))
                        launch = 1'b0;  // hold off until every write is back
                    else
                        launch = 1'b1;
                end
            end
            if (launch)
            begin
                item = pending_requests.pop_front();
                req_valid <= 1'b1;
                req_data  <= item.req;
            end
            else if (!(req_valid && req_stall))
                req_valid <= 1'b0;
        end
    end

    // Result stall bursts, with long free stretches now and then
    always @(posedge clk or negedge rst_n)
    begin
        int len;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else if (pending_requests.size() < CALM_ITEMS)
            res_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left--;
        else
        begin
            if (res_stall)
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 16);
            else
                len = $urandom_range(1, 16);
            stall_left = len - 1;
            res_stall <= !res_stall;
        end
    end

    // Monitor: predict on request accept, compare on result accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected result: index %0h value %0h",
                           res_data.written_index, res_data.written_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("written_index", want.written_index, res_data.written_index);
                    check_field("written_value", want.written_value, res_data.written_value);
                    check_field("div_zero", want.div_zero, res_data.div_zero);
                    check_field("saturated", want.saturated, res_data.saturated);
                    check_field("last", want.last, res_data.last);
                end
            end
            if (req_valid && !req_stall)
                expected_writes.push_back(predict_write(req_data));
        end
    end

    // Count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/era_pkg.sv
sv/era_ram.sv
sv/era_div.sv
sv/era_datapath.sv
sv/era_ctrl.sv
sv/expression_register_alu.sv
test/expression_register_alu_tb.sv
